// File: hdl/tkd_pkg.sv
// Package: shared types and constants for the tile key dedup id table.
package tkd_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned BaseIdW = 16;
  localparam int unsigned TileIdW = 17;

  localparam logic [BaseIdW-1:0] BaseIdReset = 16'd1;

  // One tile key: four corner class codes, NW in the top byte.
  typedef struct packed {
    logic signed [CodeW-1:0] corner_nw;
    logic signed [CodeW-1:0] corner_ne;
    logic signed [CodeW-1:0] corner_sw;
    logic signed [CodeW-1:0] corner_se;
  } tkd_in_t;

  typedef struct packed {
    logic [TileIdW-1:0] tile_id;
    logic               newly_added;
    logic               table_full;
  } tkd_out_t;

  // Status of a lookup as it travels down the cell chain.
  typedef struct packed {
    logic valid;
    logic hit;
    logic added;
  } tkd_flag_t;

endpackage

// File: hdl/tile_key_dedup_id_table_top.sv
// Top level: tile key interning table built as a systolic chain of key cells.
// Usage notes.
// Each input transaction is a tile key (four corner codes). The key walks a
// chain of TABLE_DEPTH cells, one cell per cycle unless stalled; cell j holds entry j.
// The first cell whose stored key matches gives the hit, which preserves
// insertion order. A lookup that finds no match claims the first unused
// cell (index == entry count) and writes its key there; lookups behind it
// reach that cell later and see the new entry, so back-to-back duplicates
// resolve correctly. Lookups that miss with every cell used leave the
// chain with table_full set and tile_id 0. The result is tile_id =
// base_id + entry index, added in the output register.
// Rate: one transaction per cycle while the output is not stalled; each
// result passes each cell's register in the chain, then the output register.
// A stall on the output freezes the whole chain, so order is kept.
// base_id (reset 1) is written through the cfg channel, always ready, and
// should only change while no transaction is in flight. The key store has
// no reset; only entries below the entry count are ever compared.
module tile_key_dedup_id_table_top #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tkd_pkg::BaseIdW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  tkd_pkg::tkd_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output tkd_pkg::tkd_out_t            out_data_o
);
  import tkd_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic [BaseIdW-1:0] base_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               advance;
  logic               claim_any;

  tkd_flag_t          link_flag [TABLE_DEPTH+1];
  logic [IdxW-1:0]    link_idx  [TABLE_DEPTH+1];
  tkd_in_t            link_key  [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] claim_w;

  logic     out_valid_q;
  tkd_out_t out_q, out_d;

  // Chain moves whenever the output register can take a new result.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;

  // Config: base id register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseIdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  // Chain head: a fresh lookup with no decision yet.
  assign link_flag[0] = '{valid: in_valid_i, hit: 1'b0, added: 1'b0};
  assign link_idx[0]  = '0;
  assign link_key[0]  = in_data_i;

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    tkd_cell #(
      .IdxW (IdxW),
      .CntW (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .cell_idx_i (IdxW'(j)),
      .count_i    (count_q),
      .flag_i     (link_flag[j]),
      .idx_i      (link_idx[j]),
      .key_i      (link_key[j]),
      .flag_o     (link_flag[j+1]),
      .idx_o      (link_idx[j+1]),
      .key_o      (link_key[j+1]),
      .claim_o    (claim_w[j])
    );
  end

  // Entry count: at most one cell claims per cycle.
  assign claim_any = |claim_w;
  assign count_d   = count_q + CntW'(claim_any);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Output register: form the id from the index found in the chain.
  always_comb begin
    out_d.newly_added = link_flag[TABLE_DEPTH].added;
    out_d.table_full  = !link_flag[TABLE_DEPTH].hit && !link_flag[TABLE_DEPTH].added;
    if (link_flag[TABLE_DEPTH].hit || link_flag[TABLE_DEPTH].added) begin
      out_d.tile_id = TileIdW'(base_q) + TileIdW'(link_idx[TABLE_DEPTH]);
    end else begin
      out_d.tile_id = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= link_flag[TABLE_DEPTH].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_one_claim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(claim_w))
    else $error("more than one cell claimed in a cycle");

  a_claim_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    claim_any |=> count_q == $past(count_q) + CntW'(1))
    else $error("claim did not bump the entry count");

  a_full_means_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.table_full) |-> count_q == CntW'(TABLE_DEPTH))
    else $error("full reported while entries remain");

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.newly_added && out_data_o.table_full))
    else $error("result both new and full");
`endif

endmodule

// File: hdl/tkd_cell.sv
// One table entry of the chain: holds a key and checks the passing lookup.
module tkd_cell #(
  parameter int unsigned IdxW = 8,
  parameter int unsigned CntW = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic [IdxW-1:0]    cell_idx_i,
  input  logic [CntW-1:0]    count_i,
  input  tkd_pkg::tkd_flag_t flag_i,
  input  logic [IdxW-1:0]    idx_i,
  input  tkd_pkg::tkd_in_t   key_i,
  output tkd_pkg::tkd_flag_t flag_o,
  output logic [IdxW-1:0]    idx_o,
  output tkd_pkg::tkd_in_t   key_o,
  output logic               claim_o
);
  import tkd_pkg::*;

  tkd_in_t   entry_q;
  tkd_flag_t flag_q, flag_d;
  logic [IdxW-1:0] idx_q, idx_d;
  tkd_in_t   key_q;
  logic      live, used, at_end, match, claim;

  assign live   = flag_i.valid && !flag_i.hit && !flag_i.added;
  assign used   = CntW'(cell_idx_i) < count_i;
  assign at_end = CntW'(cell_idx_i) == count_i;
  assign match  = live && used && (entry_q == key_i);
  assign claim  = live && at_end;

  always_comb begin
    flag_d.valid = flag_i.valid;
    flag_d.hit   = flag_i.hit | match;
    flag_d.added = flag_i.added | claim;
    idx_d        = (match || claim) ? cell_idx_i : idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else if (advance_i) begin
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      idx_q <= idx_d;
      key_q <= key_i;
      if (claim) begin
        entry_q <= key_i;
      end
    end
  end

  assign claim_o = advance_i && claim;
  assign flag_o  = flag_q;
  assign idx_o   = idx_q;
  assign key_o   = key_q;

endmodule
